// File: sv/bpt_pkg.sv
// ----------------------------------------------------------------------------
// Binary prefix trie package
// Shared defaults, transaction kind codes and the walker state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

  // Default sizing of the trie.
  localparam int unsigned NodeCountDef = 4096;
  localparam int unsigned AddrBitsDef  = 32;
  localparam int unsigned PrioBitsDef  = 16;

  // Width of the priority request port.
  localparam int unsigned PrioReqW = 16;

  // Transaction kind codes.
  localparam logic KindInsert = 1'b0;
  localparam logic KindLookup = 1'b1;

  // Walker sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StStep,
    StNew,
    StMark,
    StFin
  } bpt_state_e;

endpackage

`default_nettype wire

// File: sv/bpt_mem.sv
// ----------------------------------------------------------------------------
// Trie node memory
// Single write port and single read port with registered read data. The read
// data holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 41,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: sv/bpt_walk.sv
// ----------------------------------------------------------------------------
// Trie walker
// Sequencer that steps one trie level per cycle through the node memory while
// no node is allocated, allocates missing nodes on inserts, marks the final
// rule node and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_walk import bpt_pkg::*; #(
  parameter int unsigned NODE_COUNT    = NodeCountDef,
  parameter int unsigned ADDR_BITS     = AddrBitsDef,
  parameter int unsigned PRIORITY_BITS = PrioBitsDef,
  localparam int unsigned LenW = $clog2(ADDR_BITS + 1),
  localparam int unsigned IdxW = $clog2(NODE_COUNT),
  localparam int unsigned EntW = 2 * IdxW + PRIORITY_BITS + 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Request side.
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     kind_i,
  input  wire logic [ADDR_BITS-1:0]     address_i,
  input  wire logic [LenW-1:0]          len_i,
  input  wire logic [PRIORITY_BITS-1:0] prio_i,
  // Result side.
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic      [LenW-1:0]          match_depth_o,
  output logic                          pool_full_o,
  // Node memory.
  output logic                          rd_en_o,
  output logic      [IdxW-1:0]          rd_addr_o,
  input  wire logic [EntW-1:0]          rd_data_i,
  output logic                          wr_en_o,
  output logic      [IdxW-1:0]          wr_addr_o,
  output logic      [EntW-1:0]          wr_data_o
);

  // Entry layout: {child_lo, child_hi, priority, rule}.
  localparam int unsigned PrioLsb = 1;
  localparam int unsigned HiLsb   = PRIORITY_BITS + 1;
  localparam int unsigned LoLsb   = PRIORITY_BITS + IdxW + 1;

  bpt_state_e state_q, state_d;

  logic                     kind_q, kind_d;
  logic [ADDR_BITS-1:0]     addr_q, addr_d;
  logic [LenW-1:0]          len_q, len_d;
  logic [LenW-1:0]          level_q, level_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [IdxW-1:0]          node_q, node_d;
  logic                     fresh_q, fresh_d;
  logic [IdxW:0]            next_free_q, next_free_d;
  logic [IdxW-1:0]          root_lo_q, root_lo_d;
  logic [IdxW-1:0]          root_hi_q, root_hi_d;
  logic [PRIORITY_BITS-1:0] root_prio_q, root_prio_d;
  logic                     root_rule_q, root_rule_d;
  logic [LenW-1:0]          res_depth_q, res_depth_d;
  logic                     res_full_q, res_full_d;
  logic                     out_valid_q, out_valid_d;
  logic [LenW-1:0]          out_depth_q, out_depth_d;
  logic                     out_full_q, out_full_d;

  logic [EntW-1:0]          root_ent;
  logic [EntW-1:0]          cur_ent;
  logic [IdxW-1:0]          cur_lo;
  logic [IdxW-1:0]          cur_hi;
  logic [PRIORITY_BITS-1:0] cur_prio;
  logic                     cur_rule;
  logic                     cur_bit;
  logic [IdxW-1:0]          child;
  logic                     at_root;
  logic                     pool_empty;
  logic [IdxW-1:0]          new_idx;
  logic [IdxW-1:0]          upd_lo;
  logic [IdxW-1:0]          upd_hi;
  logic [PRIORITY_BITS-1:0] mark_prio;
  logic [LenW-1:0]          level_inc;
  logic [ADDR_BITS-1:0]     addr_shift;

  // Current node: the root lives in flops, a fresh node is empty, and any
  // other node comes from the memory read issued on the previous step.
  assign root_ent = {root_lo_q, root_hi_q, root_prio_q, root_rule_q};
  assign at_root  = (node_q == '0);
  assign cur_ent  = at_root ? root_ent : (fresh_q ? '0 : rd_data_i);
  assign cur_lo   = cur_ent[LoLsb +: IdxW];
  assign cur_hi   = cur_ent[HiLsb +: IdxW];
  assign cur_prio = cur_ent[PrioLsb +: PRIORITY_BITS];
  assign cur_rule = cur_ent[0];

  // Step unit: pick the child for the current address bit.
  assign cur_bit    = addr_q[ADDR_BITS-1];
  assign child      = cur_bit ? cur_hi : cur_lo;
  assign level_inc  = level_q + LenW'(1);
  assign addr_shift = {addr_q[ADDR_BITS-2:0], 1'b0};

  // Allocation from the bump counter.
  assign pool_empty = (next_free_q >= (IdxW + 1)'(NODE_COUNT));
  assign new_idx    = next_free_q[IdxW-1:0];
  assign upd_lo     = cur_bit ? cur_lo : new_idx;
  assign upd_hi     = cur_bit ? new_idx : cur_hi;

  // Rule marking keeps the larger priority of an existing rule.
  assign mark_prio = (!cur_rule || (prio_q > cur_prio)) ? prio_q : cur_prio;

  // Next state and memory control.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    len_d       = len_q;
    level_d     = level_q;
    prio_d      = prio_q;
    node_d      = node_q;
    fresh_d     = fresh_q;
    next_free_d = next_free_q;
    root_lo_d   = root_lo_q;
    root_hi_d   = root_hi_q;
    root_prio_d = root_prio_q;
    root_rule_d = root_rule_q;
    res_depth_d = res_depth_q;
    res_full_d  = res_full_q;
    out_depth_d = out_depth_q;
    out_full_d  = out_full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en_o     = 1'b0;
    rd_addr_o   = child;
    wr_en_o     = 1'b0;
    wr_addr_o   = node_q;
    wr_data_o   = cur_ent;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          kind_d      = kind_i;
          addr_d      = address_i;
          len_d       = len_i;
          prio_d      = prio_i;
          level_d     = '0;
          node_d      = '0;
          fresh_d     = 1'b0;
          res_depth_d = '0;
          res_full_d  = 1'b0;
          if ((kind_i == KindInsert) && (len_i == '0)) begin
            state_d = StFin;
          end else begin
            state_d = StStep;
          end
        end
      end

      StStep: begin
        if (level_q == len_q) begin
          if (kind_q == KindInsert) begin
            state_d = StMark;
          end else begin
            res_depth_d = level_q;
            state_d     = StFin;
          end
        end else if (kind_q == KindLookup) begin
          level_d = level_inc;
          addr_d  = addr_shift;
          if (child == '0) begin
            res_depth_d = level_inc;
            state_d     = StFin;
          end else begin
            rd_en_o = 1'b1;
            node_d  = child;
            fresh_d = 1'b0;
          end
        end else if (child != '0) begin
          rd_en_o = 1'b1;
          node_d  = child;
          fresh_d = 1'b0;
          level_d = level_inc;
          addr_d  = addr_shift;
        end else if (pool_empty) begin
          res_full_d = 1'b1;
          state_d    = StFin;
        end else begin
          // Link the new node into its parent.
          if (at_root) begin
            root_lo_d = upd_lo;
            root_hi_d = upd_hi;
          end else begin
            wr_en_o   = 1'b1;
            wr_data_o = {upd_lo, upd_hi, cur_prio, cur_rule};
          end
          next_free_d = next_free_q + (IdxW + 1)'(1);
          node_d      = new_idx;
          level_d     = level_inc;
          addr_d      = addr_shift;
          state_d     = StNew;
        end
      end

      StNew: begin
        // Clear the freshly allocated node.
        wr_en_o   = 1'b1;
        wr_data_o = '0;
        fresh_d   = 1'b1;
        state_d   = StStep;
      end

      StMark: begin
        if (at_root) begin
          root_prio_d = mark_prio;
          root_rule_d = 1'b1;
        end else begin
          wr_en_o   = 1'b1;
          wr_data_o = {cur_lo, cur_hi, mark_prio, 1'b1};
        end
        state_d = StFin;
      end

      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_depth_d = res_depth_q;
          out_full_d  = res_full_q;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      next_free_q <= (IdxW + 1)'(1);
      root_lo_q   <= '0;
      root_hi_q   <= '0;
      root_prio_q <= '0;
      root_rule_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      root_lo_q   <= root_lo_d;
      root_hi_q   <= root_hi_d;
      root_prio_q <= root_prio_d;
      root_rule_q <= root_rule_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Transaction payload.
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    addr_q      <= addr_d;
    len_q       <= len_d;
    level_q     <= level_d;
    prio_q      <= prio_d;
    node_q      <= node_d;
    fresh_q     <= fresh_d;
    res_depth_q <= res_depth_d;
    res_full_q  <= res_full_d;
    out_depth_q <= out_depth_d;
    out_full_q  <= out_full_d;
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign match_depth_o = out_depth_q;
  assign pool_full_o   = out_full_q;

endmodule

`default_nettype wire

// File: sv/binary_prefix_trie_top.sv
// Sequence: after acceptance the walker steps through the present nodes, adding
// a clear step for each node that an insert allocates and a marking step for a
// successful insert, then loads the result into the output register; a
// zero-length insert goes straight to the result. One transaction at a time:
// a new one is taken only in the idle state, after the previous result is registered.
// Reset: the root node and the allocation counter reset at once; no memory clear.
// ----------------------------------------------------------------------------
// Binary prefix trie top level
// Binary trie of address prefixes with insert and longest-path lookup,
// stored in a node memory and walked by a shared step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_prefix_trie_top import bpt_pkg::*; #(
  parameter int unsigned NODE_COUNT    = NodeCountDef,
  parameter int unsigned ADDR_BITS     = AddrBitsDef,
  parameter int unsigned PRIORITY_BITS = PrioBitsDef,
  localparam int unsigned LenW = $clog2(ADDR_BITS + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  input  wire logic [ADDR_BITS-1:0] address_i,
  input  wire logic [LenW-1:0]      rule_len_i,
  input  wire logic [PrioReqW-1:0]  priority_req_i,
  input  wire logic [LenW-1:0]      max_depth_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [LenW-1:0]      match_depth_o,
  output logic                      pool_full_o
);

  localparam int unsigned IdxW = $clog2(NODE_COUNT);
  localparam int unsigned EntW = 2 * IdxW + PRIORITY_BITS + 1;
  localparam logic [32:0] PrioMax = (33'd1 << PRIORITY_BITS) - 33'd1;

  logic [LenW-1:0]          len_sel;
  logic [LenW-1:0]          len_clip;
  logic [32:0]              req_ext;
  logic [32:0]              req_sat;
  logic [PRIORITY_BITS-1:0] prio_sat;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [EntW-1:0] rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  // Walk length: prefix length for inserts, depth limit for lookups, both
  // clipped to the address width.
  assign len_sel  = (kind_i == KindInsert) ? rule_len_i : max_depth_i;
  assign len_clip = (len_sel > LenW'(ADDR_BITS)) ? LenW'(ADDR_BITS) : len_sel;

  // Saturate the requested priority to the stored width.
  assign req_ext  = 33'(priority_req_i);
  assign req_sat  = (req_ext > PrioMax) ? PrioMax : req_ext;
  assign prio_sat = req_sat[PRIORITY_BITS-1:0];

  bpt_walk #(
    .NODE_COUNT   (NODE_COUNT),
    .ADDR_BITS    (ADDR_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .address_i    (address_i),
    .len_i        (len_clip),
    .prio_i       (prio_sat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .match_depth_o(match_depth_o),
    .pool_full_o  (pool_full_o),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  bpt_mem #(
    .Depth(NODE_COUNT),
    .Width(EntW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

endmodule

`default_nettype wire

// File: sv/bpt_checker.sv
// ----------------------------------------------------------------------------
// Binary prefix trie port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_checker import bpt_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDef,
  localparam int unsigned LenW = $clog2(ADDR_BITS + 1)
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 kind_i,
  input wire logic [ADDR_BITS-1:0] address_i,
  input wire logic [LenW-1:0]      rule_len_i,
  input wire logic [PrioReqW-1:0]  priority_req_i,
  input wire logic [LenW-1:0]      max_depth_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [LenW-1:0]      match_depth_o,
  input wire logic                 pool_full_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(match_depth_o) && $stable(pool_full_o))
    else $error("stalled result changed");

  // A waiting request keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(kind_i) && $stable(address_i) && $stable(rule_len_i) &&
      $stable(priority_req_i) && $stable(max_depth_i))
    else $error("waiting request changed");

  // A result is either a lookup depth or an insert status, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (match_depth_o != '0) |-> !pool_full_o)
    else $error("depth and full flag both set");

  // The walker is not ready in the cycle after taking a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after acceptance");

  // A lookup never reports more levels than the address has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (match_depth_o <= LenW'(ADDR_BITS)))
    else $error("match depth beyond address width");

endmodule

bind binary_prefix_trie_top bpt_checker #(
  .ADDR_BITS(ADDR_BITS)
) u_bpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .kind_i        (kind_i),
  .address_i     (address_i),
  .rule_len_i    (rule_len_i),
  .priority_req_i(priority_req_i),
  .max_depth_i   (max_depth_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .match_depth_o (match_depth_o),
  .pool_full_o   (pool_full_o)
);

`default_nettype wire

// File: dv/tb_binary_prefix_trie_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary prefix trie testbench
// Drives insert and lookup transactions into the trie and checks every result
// against a trie kept inside the testbench. Directed corner cases come first.
// Random traffic follows in three phases: clustered prefixes, long prefixes
// that use up the node pool, and reinserts and lookups on a full pool.
// ----------------------------------------------------------------------------

module tb_binary_prefix_trie_top;
  import bpt_pkg::*;

  localparam int unsigned LenW       = $clog2(AddrBitsDef + 1);
  localparam int unsigned CycleLimit = 1000000;

  // One transaction toward the block, plus a flag that holds it back until
  // every earlier result has been received.
  typedef struct packed {
    logic                kind;
    logic [AddrBitsDef-1:0] address;
    logic [LenW-1:0]     rule_len;
    logic [PrioReqW-1:0] priority_req;
    logic [LenW-1:0]     max_depth;
    logic                drain_first;
  } trie_op_t;

  typedef struct packed {
    logic [LenW-1:0] match_depth;
    logic            pool_full;
  } trie_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic         req_valid;
  logic         rsp_ready;
  trie_op_t     cur_op;
  logic         in_ready_o;
  logic         out_valid_o;
  logic [LenW-1:0] match_depth_o;
  logic         pool_full_o;

  trie_op_t     pending_q[$];
  trie_result_t expected_q[$];
  logic [AddrBitsDef-1:0] known_addr[$];
  logic [LenW-1:0]        known_len[$];

  // Shadow trie: child links, stored priority, rule flag and bump counter.
  int unsigned           kid_lo[NodeCountDef];
  int unsigned           kid_hi[NodeCountDef];
  logic [PrioBitsDef-1:0] node_weight[NodeCountDef];
  bit                    node_is_rule[NodeCountDef];
  int unsigned           alloc_next;

  int unsigned n_sent, n_got, n_err, n_inserts, n_lookups, n_full, n_deep;
  int unsigned cycle_cnt;

  binary_prefix_trie_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_valid),
    .in_ready_o     (in_ready_o),
    .kind_i         (cur_op.kind),
    .address_i      (cur_op.address),
    .rule_len_i     (cur_op.rule_len),
    .priority_req_i (cur_op.priority_req),
    .max_depth_i    (cur_op.max_depth),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (rsp_ready),
    .match_depth_o  (match_depth_o),
    .pool_full_o    (pool_full_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one transaction to the shadow trie and returns the result that
  // the block must report for it.
  function automatic trie_result_t trie_apply(trie_op_t op);
    trie_result_t res;
    int unsigned  len, lvl, cur, nxt, depth;
    bit           b, stop, present;
    res  = '0;
    cur  = 0;
    stop = 1'b0;
    if (op.kind == KindInsert) begin
      len = (op.rule_len > AddrBitsDef) ? AddrBitsDef : op.rule_len;
      for (lvl = 0; lvl < len && !stop; lvl++) begin
        b   = op.address[AddrBitsDef-1-lvl];
        nxt = b ? kid_hi[cur] : kid_lo[cur];
        if (nxt == 0) begin
          if (alloc_next >= NodeCountDef) begin
            // Pool exhausted: the partial path stays, no rule is marked.
            res.pool_full = 1'b1;
            stop = 1'b1;
          end else begin
            nxt = alloc_next;
            alloc_next++;
            kid_lo[nxt]       = 0;
            kid_hi[nxt]       = 0;
            node_weight[nxt]  = '0;
            node_is_rule[nxt] = 1'b0;
            if (b) kid_hi[cur] = nxt;
            else   kid_lo[cur] = nxt;
          end
        end
        if (!stop) cur = nxt;
      end
      // The request port is as wide as the stored priority, so clipping
      // leaves the value as it is.
      if (len != 0 && !res.pool_full) begin
        if (!node_is_rule[cur] || op.priority_req > node_weight[cur]) begin
          node_weight[cur] = op.priority_req;
        end
        node_is_rule[cur] = 1'b1;
      end
    end else begin
      len     = (op.max_depth > AddrBitsDef) ? AddrBitsDef : op.max_depth;
      depth   = 0;
      present = 1'b1;
      while (depth < len && present) begin
        cur     = op.address[AddrBitsDef-1-depth] ? kid_hi[cur] : kid_lo[cur];
        present = (cur != 0);
        depth++;
      end
      res.match_depth = LenW'(depth);
    end
    return res;
  endfunction

  // Queues one transaction and remembers the prefixes of inserts.
  task automatic add_op(input logic kind, input logic [AddrBitsDef-1:0] addr,
                        input logic [LenW-1:0] plen, input logic [PrioReqW-1:0] prio,
                        input logic [LenW-1:0] mdep, input logic drain);
    trie_op_t op;
    op.kind         = kind;
    op.address      = addr;
    op.rule_len     = plen;
    op.priority_req = prio;
    op.max_depth    = mdep;
    op.drain_first  = drain;
    pending_q.push_back(op);
    if (kind == KindInsert) begin
      known_addr.push_back(addr);
      known_len.push_back(plen);
    end
  endtask

  // Picks an address near a known prefix most of the time, else a fresh one.
  function automatic logic [AddrBitsDef-1:0] pick_addr();
    logic [AddrBitsDef-1:0] a;
    int unsigned idx;
    if (known_addr.size() == 0 || $urandom_range(99) < 30) return $urandom;
    a = known_addr[$urandom_range(known_addr.size() - 1)];
    if ($urandom_range(99) < 40) begin
      idx    = $urandom_range(AddrBitsDef - 1);
      a[idx] = ~a[idx];
    end
    return a;
  endfunction

  // Length with some zeros and some values past the address width.
  function automatic logic [LenW-1:0] pick_len(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 12) return LenW'($urandom_range(63, AddrBitsDef + 1));
    return LenW'($urandom_range(hi, 1));
  endfunction

  // Sender: presents queued transactions, idles at random, and predicts the
  // result of each transaction at the edge where it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      cur_op    <= '0;
    end else begin : drive_step
      bit accepted, hold_off, calm;
      accepted = req_valid && in_ready_o;
      calm     = (n_sent >= 600) && (n_sent < 800);
      if (accepted) begin
        expected_q.push_back(trie_apply(cur_op));
        n_sent++;
        if (cur_op.kind == KindInsert) n_inserts++;
        else                           n_lookups++;
      end
      if (!req_valid || accepted) begin
        hold_off = (pending_q.size() == 0) ||
                   (!calm && $urandom_range(99) < 24) ||
                   (pending_q[0].drain_first && expected_q.size() != 0);
        if (!hold_off) begin
          cur_op    <= pending_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks each result against the oldest
  // prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin : check_step
      trie_result_t want;
      if (out_valid_o && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: match_depth=%0d pool_full=%0b",
                 match_depth_o, pool_full_o);
          n_err++;
        end else begin
          want = expected_q.pop_front();
          if (match_depth_o !== want.match_depth) begin
            $error("match_depth: expected %0d, got %0d", want.match_depth, match_depth_o);
            n_err++;
          end
          if (pool_full_o !== want.pool_full) begin
            $error("pool_full: expected %0b, got %0b", want.pool_full, pool_full_o);
            n_err++;
          end
          if (want.pool_full) n_full++;
          if (want.match_depth == AddrBitsDef) n_deep++;
        end
        n_got++;
      end
      rsp_ready <= ((n_got >= 600) && (n_got < 800)) || ($urandom_range(99) >= 24);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned i, r, idx;
    bit          drain;

    // Shadow trie after reset: the root alone, marked as a rule.
    for (i = 0; i < NodeCountDef; i++) begin
      kid_lo[i]       = 0;
      kid_hi[i]       = 0;
      node_weight[i]  = '0;
      node_is_rule[i] = 1'b0;
    end
    node_is_rule[0] = 1'b1;
    alloc_next      = 1;

    // Directed corner cases.
    add_op(KindLookup, 32'h0000_0000, 6'd0,  16'h0000, 6'd0,  1'b0);
    add_op(KindLookup, 32'h0000_0000, 6'd0,  16'h0000, 6'd32, 1'b0);
    add_op(KindInsert, 32'h8000_0000, 6'd0,  16'hFFFF, 6'd0,  1'b0);
    add_op(KindLookup, 32'h8000_0000, 6'd0,  16'h0000, 6'd32, 1'b0);
    add_op(KindInsert, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 6'd0,  1'b0);
    add_op(KindLookup, 32'hFFFF_FFFF, 6'd0,  16'h0000, 6'd32, 1'b0);
    add_op(KindLookup, 32'hFFFF_FFFF, 6'd0,  16'h0000, 6'd63, 1'b0);
    add_op(KindLookup, 32'hFFFF_FFFE, 6'd0,  16'h0000, 6'd32, 1'b0);
    add_op(KindInsert, 32'h0000_0000, 6'd63, 16'h0000, 6'd63, 1'b0);
    add_op(KindLookup, 32'h0000_0000, 6'd0,  16'h0000, 6'd33, 1'b0);
    // Same rule three times: lower, then higher priority.
    add_op(KindInsert, 32'hFFFF_0000, 6'd16, 16'h0005, 6'd0,  1'b0);
    add_op(KindInsert, 32'hFFFF_0000, 6'd16, 16'h0003, 6'd0,  1'b0);
    add_op(KindInsert, 32'hFFFF_0000, 6'd16, 16'hFFFF, 6'd0,  1'b0);
    add_op(KindLookup, 32'hFFFF_1234, 6'd0,  16'h0000, 6'd20, 1'b0);
    add_op(KindInsert, 32'hA5A5_A5A5, 6'd1,  16'h0001, 6'd0,  1'b0);
    add_op(KindLookup, 32'h5A5A_5A5A, 6'd0,  16'h0000, 6'd1,  1'b0);
    add_op(KindLookup, 32'h7FFF_FFFF, 6'd63, 16'hFFFF, 6'd2,  1'b0);

    // Clustered prefixes of moderate length mixed with lookups.
    for (i = 0; i < 900; i++) begin
      drain = (i == 0) || ($urandom_range(99) == 0);
      if ($urandom_range(99) < 45) begin
        add_op(KindInsert, pick_addr(), pick_len(24), PrioReqW'($urandom),
               LenW'($urandom), drain);
      end else begin
        add_op(KindLookup, pick_addr(), LenW'($urandom), PrioReqW'($urandom),
               pick_len(AddrBitsDef), drain);
      end
    end

    // Full-length prefixes on fresh addresses until the node pool runs dry.
    for (i = 0; i < 250; i++) begin
      drain = (i == 0) || ($urandom_range(99) == 0);
      if ($urandom_range(99) < 80) begin
        add_op(KindInsert, $urandom, LenW'(AddrBitsDef), PrioReqW'($urandom),
               LenW'($urandom), drain);
      end else begin
        add_op(KindLookup, pick_addr(), LenW'($urandom), PrioReqW'($urandom),
               pick_len(AddrBitsDef), drain);
      end
    end

    // Full pool: reinserts along existing paths, failing inserts, lookups.
    for (i = 0; i < 750; i++) begin
      drain = (i == 0) || ($urandom_range(99) == 0);
      r     = $urandom_range(99);
      if (r < 40) begin
        idx = $urandom_range(known_addr.size() - 1);
        add_op(KindInsert, known_addr[idx], known_len[idx], PrioReqW'($urandom),
               LenW'($urandom), drain);
      end else if (r < 55) begin
        add_op(KindInsert, $urandom, pick_len(AddrBitsDef), PrioReqW'($urandom),
               LenW'($urandom), drain);
      end else begin
        add_op(KindLookup, pick_addr(), LenW'($urandom), PrioReqW'($urandom),
               pick_len(AddrBitsDef), drain);
      end
    end

    // Hold reset, then release it away from the rising edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for all stimulus to be accepted and all results to arrive.
    while (pending_q.size() != 0 || req_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Ran %0d inserts and %0d lookups; %0d results checked.",
             n_inserts, n_lookups, n_got);
    $display("Pool ran out on %0d inserts; %0d lookups matched all 32 levels.",
             n_full, n_deep);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
